// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent check macros shared by the RTL; they expect clk_i and rst_ni in
// the scope that uses them. They compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define SRP_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("srp check failed");
`define SRP_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("srp forbidden condition seen");
`else
`define SRP_ASSERT(name, prop)
`define SRP_ASSERT_NEVER(name, cond)
`endif

`endif

// File: src/srp_pkg.sv
// ----------------------------------------------------------------------------
// srp_pkg
// Shared types, codes and widths of the sensor report-on-change policy.
// ----------------------------------------------------------------------------
package srp_pkg;

  localparam int unsigned TempW       = 16;
  localparam int unsigned PressW      = 17;
  localparam int unsigned HumW        = 17;
  localparam int unsigned HandleW     = 12;
  localparam int unsigned AdvHumW     = 14;
  localparam int unsigned CfgW        = 17;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned FuncW       = 3;
  localparam int unsigned KindW       = 2;
  localparam int unsigned ResCntW     = 2;

  // Humidity to 0.01 %RH: multiply by 100, drop 10 fraction bits.
  localparam int unsigned HumScaleNum   = 100;
  localparam int unsigned HumScaleShift = 10;
  localparam int unsigned HumProdW      = HumScaleShift + AdvHumW;

  localparam logic [TempW-1:0]  TempThrRst  = 16'd10;
  localparam logic [HumW-1:0]   HumThrRst   = 17'd1024;
  localparam logic [PressW-1:0] PressThrRst = 17'd50;

  typedef enum logic [FuncW-1:0] {
    FUNC_READING   = 3'd0,
    FUNC_LINK_UP   = 3'd1,
    FUNC_LINK_DOWN = 3'd2,
    FUNC_SUBSCRIBE = 3'd3,
    FUNC_ACTIVITY  = 3'd4,
    FUNC_PUBLISH   = 3'd5
  } func_e;

  typedef enum logic [KindW-1:0] {
    KIND_RUN_REQ = 2'd0,
    KIND_SPEED   = 2'd1,
    KIND_NOTIFY  = 2'd2,
    KIND_ADV     = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TEMP_THR  = 2'd0,
    CFG_HUM_THR   = 2'd1,
    CFG_PRESS_THR = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [FuncW-1:0]        func;
    logic signed [TempW-1:0] temperature;
    logic [PressW-1:0]       pressure;
    logic [HumW-1:0]         humidity;
    logic [HandleW-1:0]      link_handle;
    logic                    subscribed;
    logic                    active_mode;
    logic                    notify_ok;
    logic                    adv_ok;
  } event_t;

  typedef struct packed {
    kind_e                   kind;
    logic                    last;
    logic [HandleW-1:0]      handle;
    logic                    use_fast;
    logic signed [TempW-1:0] temperature;
    logic [PressW-1:0]       pressure;
    logic [HumW-1:0]         humidity;
    logic signed [TempW-1:0] adv_temperature;
    logic [AdvHumW-1:0]      adv_humidity;
  } result_t;

  localparam result_t ResultZero = '0;

endpackage

// File: src/sensor_report_on_change_policy.sv
// ----------------------------------------------------------------------------
// sensor_report_on_change_policy
// Report-by-exception publish policy: events in, publish requests, link
// speed requests, notifications and advertisement updates out.
// ----------------------------------------------------------------------------
// One event is taken per clock cycle while in_ready_o is high. It is decided
// in the same cycle from the stored state into a two-entry result register,
// so every result appears in the cycle after its event at the earliest.
// Results leave one transfer per cycle while out_ready_i is high; a publish
// with a speed request and a notification fills both entries, and events
// are taken while the buffer is empty or its single result is taken in that
// cycle. The user must write threshold registers via the cfg port only while
// no event is in flight; it is not enforced. No clearing pass after reset.
// ----------------------------------------------------------------------------

module sensor_report_on_change_policy (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [srp_pkg::CfgIdxW-1:0]          cfg_addr_i,
  input  logic [srp_pkg::CfgW-1:0]             cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [srp_pkg::FuncW-1:0]            func_i,
  input  logic signed [srp_pkg::TempW-1:0]     temperature_i,
  input  logic [srp_pkg::PressW-1:0]           pressure_i,
  input  logic [srp_pkg::HumW-1:0]             humidity_i,
  input  logic [srp_pkg::HandleW-1:0]          link_handle_i,
  input  logic                                 subscribed_i,
  input  logic                                 active_mode_i,
  input  logic                                 notify_ok_i,
  input  logic                                 adv_ok_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [srp_pkg::KindW-1:0]            kind_o,
  output logic                                 last_o,
  output logic [srp_pkg::HandleW-1:0]          out_handle_o,
  output logic                                 use_fast_o,
  output logic signed [srp_pkg::TempW-1:0]     out_temperature_o,
  output logic [srp_pkg::PressW-1:0]           out_pressure_o,
  output logic [srp_pkg::HumW-1:0]             out_humidity_o,
  output logic signed [srp_pkg::TempW-1:0]     adv_temperature_o,
  output logic [srp_pkg::AdvHumW-1:0]          adv_humidity_o
);

  srp_pkg::event_t             ev;
  srp_pkg::result_t            res0;
  srp_pkg::result_t            res1;
  srp_pkg::result_t            head;
  logic [srp_pkg::ResCntW-1:0] res_cnt;
  logic                        accept;

  always_comb begin
    ev.func        = func_i;
    ev.temperature = temperature_i;
    ev.pressure    = pressure_i;
    ev.humidity    = humidity_i;
    ev.link_handle = link_handle_i;
    ev.subscribed  = subscribed_i;
    ev.active_mode = active_mode_i;
    ev.notify_ok   = notify_ok_i;
    ev.adv_ok      = adv_ok_i;
  end

  assign accept = in_valid_i && in_ready_o;

  srp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .ev_i        (ev),
    .res_cnt_o   (res_cnt),
    .res0_o      (res0),
    .res1_o      (res1)
  );

  srp_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .res_cnt_i   (res_cnt),
    .res0_i      (res0),
    .res1_i      (res1),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign kind_o            = head.kind;
  assign last_o            = head.last;
  assign out_handle_o      = head.handle;
  assign use_fast_o        = head.use_fast;
  assign out_temperature_o = head.temperature;
  assign out_pressure_o    = head.pressure;
  assign out_humidity_o    = head.humidity;
  assign adv_temperature_o = head.adv_temperature;
  assign adv_humidity_o    = head.adv_humidity;

endmodule

// File: src/srp_core.sv
// ----------------------------------------------------------------------------
// srp_core
// Policy state, threshold registers and per-event result decision.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module srp_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [srp_pkg::CfgIdxW-1:0]          cfg_addr_i,
  input  logic [srp_pkg::CfgW-1:0]             cfg_wdata_i,
  input  logic                                 accept_i,
  input  srp_pkg::event_t                      ev_i,
  output logic [srp_pkg::ResCntW-1:0]          res_cnt_o,
  output srp_pkg::result_t                     res0_o,
  output srp_pkg::result_t                     res1_o
);

  logic [srp_pkg::TempW-1:0]  temp_thr_q;
  logic [srp_pkg::HumW-1:0]   hum_thr_q;
  logic [srp_pkg::PressW-1:0] press_thr_q;

  logic signed [srp_pkg::TempW-1:0] latest_temp_q, latest_temp_d;
  logic [srp_pkg::PressW-1:0]       latest_press_q, latest_press_d;
  logic [srp_pkg::HumW-1:0]         latest_hum_q, latest_hum_d;
  logic signed [srp_pkg::TempW-1:0] told_temp_q, told_temp_d;
  logic [srp_pkg::PressW-1:0]       told_press_q, told_press_d;
  logic [srp_pkg::HumW-1:0]         told_hum_q, told_hum_d;
  logic [srp_pkg::HandleW-1:0]      saved_handle_q, saved_handle_d;

  logic have_latest_q, have_latest_d;
  logic have_told_q, have_told_d;
  logic link_up_q, link_up_d;
  logic notify_on_q, notify_on_d;
  logic adv_stale_q, adv_stale_d;
  logic speed_pending_q, speed_pending_d;
  logic fast_mode_q, fast_mode_d;

  logic signed [srp_pkg::TempW:0] temp_diff;
  logic [srp_pkg::TempW:0]        temp_abs;
  logic [srp_pkg::HumW-1:0]       hum_abs;
  logic [srp_pkg::PressW-1:0]     press_abs;
  logic                           worth;
  logic [srp_pkg::HumProdW-1:0]   hum_prod;

  logic speed_fire;
  logic speed_res;
  logic notify_res;
  logic adv_res;
  logic publish_acc;

  srp_pkg::result_t r_speed, r_notify, r_adv, r_req;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_thr_q  <= srp_pkg::TempThrRst;
      hum_thr_q   <= srp_pkg::HumThrRst;
      press_thr_q <= srp_pkg::PressThrRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        srp_pkg::CFG_TEMP_THR:  temp_thr_q  <= cfg_wdata_i[srp_pkg::TempW-1:0];
        srp_pkg::CFG_HUM_THR:   hum_thr_q   <= cfg_wdata_i[srp_pkg::HumW-1:0];
        srp_pkg::CFG_PRESS_THR: press_thr_q <= cfg_wdata_i[srp_pkg::PressW-1:0];
        default: ;
      endcase
    end
  end

  // Change detection against the last reported reading.
  always_comb begin
    temp_diff = {latest_temp_q[srp_pkg::TempW-1], latest_temp_q}
              - {told_temp_q[srp_pkg::TempW-1], told_temp_q};
    temp_abs  = temp_diff[srp_pkg::TempW] ? 17'(-temp_diff) : 17'(temp_diff);
    hum_abs   = (latest_hum_q >= told_hum_q) ? (latest_hum_q - told_hum_q)
                                             : (told_hum_q - latest_hum_q);
    press_abs = (latest_press_q >= told_press_q) ? (latest_press_q - told_press_q)
                                                 : (told_press_q - latest_press_q);
    worth = !have_told_q
          || (temp_abs >= {1'b0, temp_thr_q})
          || (hum_abs >= hum_thr_q)
          || (press_abs >= press_thr_q);
    hum_prod = srp_pkg::HumProdW'(latest_hum_q) * srp_pkg::HumProdW'(srp_pkg::HumScaleNum);
  end

  assign speed_fire  = speed_pending_q && notify_on_q;
  assign speed_res   = speed_fire && link_up_q;
  assign notify_res  = have_latest_q && link_up_q && notify_on_q && worth;
  assign adv_res     = have_latest_q && !link_up_q && adv_stale_q;
  assign publish_acc = accept_i && (ev_i.func == srp_pkg::FUNC_PUBLISH);

  always_comb begin
    r_speed          = srp_pkg::ResultZero;
    r_speed.kind     = srp_pkg::KIND_SPEED;
    r_speed.handle   = saved_handle_q;
    r_speed.use_fast = fast_mode_q;

    r_notify             = srp_pkg::ResultZero;
    r_notify.kind        = srp_pkg::KIND_NOTIFY;
    r_notify.temperature = latest_temp_q;
    r_notify.pressure    = latest_press_q;
    r_notify.humidity    = latest_hum_q;

    r_adv                 = srp_pkg::ResultZero;
    r_adv.kind            = srp_pkg::KIND_ADV;
    r_adv.adv_temperature = latest_temp_q;
    r_adv.adv_humidity    = hum_prod[srp_pkg::HumProdW-1 -: srp_pkg::AdvHumW];

    r_req      = srp_pkg::ResultZero;
    r_req.kind = srp_pkg::KIND_RUN_REQ;
    r_req.last = 1'b1;
  end

  always_comb begin
    latest_temp_d   = latest_temp_q;
    latest_press_d  = latest_press_q;
    latest_hum_d    = latest_hum_q;
    told_temp_d     = told_temp_q;
    told_press_d    = told_press_q;
    told_hum_d      = told_hum_q;
    saved_handle_d  = saved_handle_q;
    have_latest_d   = have_latest_q;
    have_told_d     = have_told_q;
    link_up_d       = link_up_q;
    notify_on_d     = notify_on_q;
    adv_stale_d     = adv_stale_q;
    speed_pending_d = speed_pending_q;
    fast_mode_d     = fast_mode_q;
    res_cnt_o       = '0;
    res0_o          = srp_pkg::ResultZero;
    res1_o          = srp_pkg::ResultZero;

    case (ev_i.func)
      srp_pkg::FUNC_READING: begin
        latest_temp_d  = ev_i.temperature;
        latest_press_d = ev_i.pressure;
        latest_hum_d   = ev_i.humidity;
        have_latest_d  = 1'b1;
        adv_stale_d    = 1'b1;
        res_cnt_o      = 2'd1;
        res0_o         = r_req;
      end
      srp_pkg::FUNC_LINK_UP: begin
        saved_handle_d = ev_i.link_handle;
        link_up_d      = 1'b1;
        have_told_d    = 1'b0;
      end
      srp_pkg::FUNC_LINK_DOWN: begin
        link_up_d       = 1'b0;
        notify_on_d     = 1'b0;
        have_told_d     = 1'b0;
        fast_mode_d     = 1'b0;
        speed_pending_d = 1'b0;
        adv_stale_d     = 1'b1;
        res_cnt_o       = 2'd1;
        res0_o          = r_req;
      end
      srp_pkg::FUNC_SUBSCRIBE: begin
        notify_on_d = ev_i.subscribed;
        if (ev_i.subscribed) begin
          speed_pending_d = 1'b1;
          have_told_d     = 1'b0;
          res_cnt_o       = 2'd1;
          res0_o          = r_req;
        end
      end
      srp_pkg::FUNC_ACTIVITY: begin
        fast_mode_d = ev_i.active_mode;
        if (link_up_q && (ev_i.active_mode != fast_mode_q)) begin
          speed_pending_d = 1'b1;
          res_cnt_o       = 2'd1;
          res0_o          = r_req;
        end
      end
      srp_pkg::FUNC_PUBLISH: begin
        // A pending speed request is consumed even when the link is down.
        if (speed_fire) begin
          speed_pending_d = 1'b0;
        end
        if (notify_res && ev_i.notify_ok) begin
          told_temp_d  = latest_temp_q;
          told_press_d = latest_press_q;
          told_hum_d   = latest_hum_q;
          have_told_d  = 1'b1;
        end
        if (adv_res && ev_i.adv_ok) begin
          adv_stale_d = 1'b0;
        end
        res_cnt_o = {1'b0, speed_res} + {1'b0, notify_res} + {1'b0, adv_res};
        if (speed_res) begin
          res0_o = r_speed;
        end else if (notify_res) begin
          res0_o = r_notify;
        end else if (adv_res) begin
          res0_o = r_adv;
        end
        if (speed_res && notify_res) begin
          res1_o      = r_notify;
          res1_o.last = 1'b1;
        end else begin
          res0_o.last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Readings and reported values are only read once their flag is set.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      latest_temp_q  <= latest_temp_d;
      latest_press_q <= latest_press_d;
      latest_hum_q   <= latest_hum_d;
      told_temp_q    <= told_temp_d;
      told_press_q   <= told_press_d;
      told_hum_q     <= told_hum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      saved_handle_q  <= '0;
      have_latest_q   <= 1'b0;
      have_told_q     <= 1'b0;
      link_up_q       <= 1'b0;
      notify_on_q     <= 1'b0;
      adv_stale_q     <= 1'b0;
      speed_pending_q <= 1'b0;
      fast_mode_q     <= 1'b0;
    end else if (accept_i) begin
      saved_handle_q  <= saved_handle_d;
      have_latest_q   <= have_latest_d;
      have_told_q     <= have_told_d;
      link_up_q       <= link_up_d;
      notify_on_q     <= notify_on_d;
      adv_stale_q     <= adv_stale_d;
      speed_pending_q <= speed_pending_d;
      fast_mode_q     <= fast_mode_d;
    end
  end

  `SRP_ASSERT_NEVER(a_notify_adv_excl, notify_res && adv_res)
  `SRP_ASSERT(a_told_taken, (publish_acc && notify_res && ev_i.notify_ok) |=> have_told_q)
  `SRP_ASSERT(a_speed_cleared, (publish_acc && speed_fire) |=> !speed_pending_q)

endmodule

// File: src/srp_obuf.sv
// ----------------------------------------------------------------------------
// srp_obuf
// Two-entry result buffer; holds all results of one event and drains them
// one transfer per cycle while out_ready_i is high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module srp_obuf (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [srp_pkg::ResCntW-1:0]   res_cnt_i,
  input  srp_pkg::result_t              res0_i,
  input  srp_pkg::result_t              res1_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output srp_pkg::result_t              head_o
);

  logic [srp_pkg::ResCntW-1:0] cnt_q;
  srp_pkg::result_t            slot_q [2];
  logic                        push;
  logic                        pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  // Take an event when the buffer is empty or its only entry leaves now.
  assign in_ready_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);
  assign push        = in_valid_i && in_ready_o;
  assign head_o      = slot_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (push) begin
      cnt_q <= res_cnt_i;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[0] <= res0_i;
      slot_q[1] <= res1_i;
    end else if (pop) begin
      slot_q[0] <= slot_q[1];
    end
  end

  `SRP_ASSERT(a_push_when_empty, push |-> ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop)))
  `SRP_ASSERT(a_pair_order, (cnt_q == 2'd2) |-> (!slot_q[0].last && slot_q[1].last))
  `SRP_ASSERT(a_single_last, (cnt_q == 2'd1) |-> slot_q[0].last)
  `SRP_ASSERT_NEVER(a_cnt_range, cnt_q == 2'd3)

endmodule
